>>> rtl/slicing_floorplan_size_eval_unit_macros.svh
// Assertion macros shared by the slicing floorplan size evaluator modules.
`ifndef SLICING_FLOORPLAN_SIZE_EVAL_UNIT_MACROS_SVH
`define SLICING_FLOORPLAN_SIZE_EVAL_UNIT_MACROS_SVH
`ifndef SYNTH
// The consequence must hold in the same cycle as the condition.
`define SFE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfe: assertion failed");
// The consequence must hold in the cycle after the condition.
`define SFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfe: assertion failed");
`else
`define SFE_ASSERT_SAME(label, clk, rst, ante, cons)
`define SFE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/sfe_pkg.sv
// Types, constants and helper functions of the slicing floorplan size evaluator.
`timescale 1ns / 1ps
`default_nettype none

package sfe_pkg;

   localparam int MAX_MODULES_DEF = 64;
   localparam int DIM_BITS_DEF    = 16;
   localparam int STACK_DEPTH_DEF = 64;

   localparam int IDX_W  = 6;
   localparam int LOAD_W = 16;
   localparam int SIZE_W = 22;
   localparam int POS_W  = 7;
   localparam int ERR_W  = 3;

   localparam logic [SIZE_W-1:0] SIZE_LIMIT = '1;
   localparam logic [POS_W-1:0]  POS_LIMIT  = '1;

   // Result queue slots; enough to keep one last token per cycle flowing while results are taken.
   localparam int RSP_SLOTS = 3;
   localparam int RSP_CNT_W = $clog2(RSP_SLOTS + 1);
   localparam int RSP_PTR_W = $clog2(RSP_SLOTS);

   typedef enum logic [1:0] {
      MODE_LOAD,
      MODE_OPERAND,
      MODE_CUT_H,
      MODE_CUT_V
   } mode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE,
      ERR_UNDERFLOW,
      ERR_REPEAT,
      ERR_UNBALANCED,
      ERR_OVERFLOW
   } err_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUSH,
      OP_CUT_H,
      OP_CUT_V
   } op_type;

   typedef struct packed {
      mode_type          mode;
      logic [IDX_W-1:0]  module_index;
      logic [LOAD_W-1:0] load_width;
      logic [LOAD_W-1:0] load_height;
      logic              last_token;
   } req_type;

   typedef struct packed {
      logic [SIZE_W-1:0] total_width;
      logic [SIZE_W-1:0] total_height;
      err_type           error_code;
      logic [POS_W-1:0]  fault_position;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
   } size_type;

   // Token that has passed the control stage and now acts on the stack.
   typedef struct packed {
      logic             valid;
      op_type           op;
      logic             last;
      err_type          err_code;
      logic [POS_W-1:0] err_pos;
      size_type         push_val;
   } stage_type;

   function automatic logic [SIZE_W-1:0] sat_size(input logic [32:0] v);
      logic [SIZE_W-1:0] r;
      if (v > 33'(SIZE_LIMIT)) begin
         r = SIZE_LIMIT;
      end else begin
         r = v[SIZE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/sfe_stack_cell.sv
// One stack cell: holds a (width, height) entry and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module sfe_stack_cell
   import sfe_pkg::*;
(
   input  logic     clock,
   input  op_type   op,
   input  size_type above,
   input  size_type below,
   output size_type q
);

   size_type entry_ff;
   size_type entry_in;

   // A push moves every entry one cell deeper; a cut pulls them back up.
   always_comb begin
      unique case (op)
         OP_PUSH:            entry_in = above;
         OP_CUT_H, OP_CUT_V: entry_in = below;
         OP_NONE:            entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

`default_nettype wire

>>> rtl/sfe_token_ctrl.sv
// Token checker: dimension store, stack depth bookkeeping and fault tracking.
`timescale 1ns / 1ps
`default_nettype none
`include "slicing_floorplan_size_eval_unit_macros.svh"

module sfe_token_ctrl
   import sfe_pkg::*;
#(
   parameter int MAX_MODULES = MAX_MODULES_DEF,
   parameter int DIM_BITS    = DIM_BITS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   item,
   output stage_type stage
);

   localparam int ADDR_W  = $clog2(MAX_MODULES);
   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

   logic [2*DIM_BITS-1:0] dim_mem [MAX_MODULES];
   logic [2*DIM_BITS-1:0] rd_ff;
   logic                  in_range_ff;

   logic [31:0]           idx_ext;
   logic [ADDR_W-1:0]     addr;
   logic                  in_range;
   logic [2*DIM_BITS-1:0] load_val;
   logic                  is_token;

   logic [DEPTH_W-1:0] depth_ff, depth_in, depth_next;
   logic               prev_valid_ff, prev_valid_in;
   mode_type           prev_kind_ff, prev_kind_in;
   logic [IDX_W-1:0]   prev_idx_ff, prev_idx_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   err_type            err_ff, err_in, err_next, fault;
   logic [POS_W-1:0]   err_pos_ff, err_pos_in, err_pos_next;
   op_type             op;

   logic               s_valid_ff, s_valid_in;
   op_type             s_op_ff, s_op_in;
   logic               s_last_ff, s_last_in;
   err_type            s_err_ff, s_err_in;
   logic [POS_W-1:0]   s_err_pos_ff, s_err_pos_in;

   assign idx_ext  = 32'(item.module_index);
   assign addr     = idx_ext[ADDR_W-1:0];
   assign in_range = idx_ext < 32'(MAX_MODULES);
   assign load_val = {DIM_BITS'(32'(item.load_width)), DIM_BITS'(32'(item.load_height))};
   assign is_token = accept && (item.mode != MODE_LOAD);

   always_ff @(posedge clock) begin
      if (accept && item.mode == MODE_LOAD && in_range) begin
         dim_mem[addr] <= load_val;
      end
      if (accept && item.mode == MODE_OPERAND) begin
         rd_ff       <= dim_mem[addr];
         in_range_ff <= in_range;
      end
   end

   always_comb begin
      depth_in      = depth_ff;
      prev_valid_in = prev_valid_ff;
      prev_kind_in  = prev_kind_ff;
      prev_idx_in   = prev_idx_ff;
      pos_in        = pos_ff;
      err_in        = err_ff;
      err_pos_in    = err_pos_ff;
      depth_next    = depth_ff;
      fault         = ERR_NONE;
      op            = OP_NONE;
      err_next      = err_ff;
      err_pos_next  = err_pos_ff;
      s_valid_in    = 1'b0;
      s_op_in       = OP_NONE;
      s_last_in     = 1'b0;
      s_err_in      = err_ff;
      s_err_pos_in  = err_pos_ff;

      if (is_token) begin
         if (err_ff == ERR_NONE) begin
            if (item.mode == MODE_OPERAND) begin
               if (prev_valid_ff && prev_kind_ff == MODE_OPERAND &&
                   prev_idx_ff == item.module_index) begin
                  fault = ERR_REPEAT;
               end else if (depth_ff >= DEPTH_W'(STACK_DEPTH)) begin
                  fault = ERR_OVERFLOW;
               end else begin
                  op         = OP_PUSH;
                  depth_next = depth_ff + DEPTH_W'(1);
               end
            end else begin
               // Underflow takes priority over a repeated operator.
               if (depth_ff < DEPTH_W'(2)) begin
                  fault = ERR_UNDERFLOW;
               end else if (prev_valid_ff && prev_kind_ff == item.mode) begin
                  fault = ERR_REPEAT;
               end else begin
                  op         = (item.mode == MODE_CUT_H) ? OP_CUT_H : OP_CUT_V;
                  depth_next = depth_ff - DEPTH_W'(1);
               end
            end
            if (fault != ERR_NONE) begin
               err_next     = fault;
               err_pos_next = pos_ff;
            end
         end

         if (item.last_token && err_next == ERR_NONE && depth_next != DEPTH_W'(1)) begin
            err_next     = ERR_UNBALANCED;
            err_pos_next = pos_ff;
         end

         s_valid_in   = 1'b1;
         s_op_in      = op;
         s_last_in    = item.last_token;
         s_err_in     = err_next;
         s_err_pos_in = err_pos_next;

         if (item.last_token) begin
            depth_in      = '0;
            prev_valid_in = 1'b0;
            prev_kind_in  = MODE_LOAD;
            prev_idx_in   = '0;
            pos_in        = '0;
            err_in        = ERR_NONE;
            err_pos_in    = '0;
         end else begin
            depth_in      = depth_next;
            prev_valid_in = 1'b1;
            prev_kind_in  = item.mode;
            prev_idx_in   = item.module_index;
            pos_in        = (pos_ff == POS_LIMIT) ? pos_ff : pos_ff + POS_W'(1);
            err_in        = err_next;
            err_pos_in    = err_pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         prev_valid_ff <= 1'b0;
         prev_kind_ff  <= MODE_LOAD;
         prev_idx_ff   <= '0;
         pos_ff        <= '0;
         err_ff        <= ERR_NONE;
         err_pos_ff    <= '0;
         s_valid_ff    <= 1'b0;
         s_op_ff       <= OP_NONE;
      end else begin
         depth_ff      <= depth_in;
         prev_valid_ff <= prev_valid_in;
         prev_kind_ff  <= prev_kind_in;
         prev_idx_ff   <= prev_idx_in;
         pos_ff        <= pos_in;
         err_ff        <= err_in;
         err_pos_ff    <= err_pos_in;
         s_valid_ff    <= s_valid_in;
         s_op_ff       <= s_op_in;
      end
   end

   always_ff @(posedge clock) begin
      s_last_ff    <= s_last_in;
      s_err_ff     <= s_err_in;
      s_err_pos_ff <= s_err_pos_in;
   end

   assign stage.valid      = s_valid_ff;
   assign stage.op         = s_op_ff;
   assign stage.last       = s_last_ff;
   assign stage.err_code   = s_err_ff;
   assign stage.err_pos    = s_err_pos_ff;
   assign stage.push_val.w = in_range_ff ? sat_size(33'(rd_ff[2*DIM_BITS-1:DIM_BITS])) : '0;
   assign stage.push_val.h = in_range_ff ? sat_size(33'(rd_ff[DIM_BITS-1:0])) : '0;

   `SFE_ASSERT_SAME(a_depth_bound, clock, reset, 1'b1, depth_ff <= DEPTH_W'(STACK_DEPTH))
   `SFE_ASSERT_NEXT(a_clear_after_last, clock, reset, is_token && item.last_token, depth_ff == '0 && err_ff == ERR_NONE && pos_ff == '0 && !prev_valid_ff)
   `SFE_ASSERT_NEXT(a_fault_sticky, clock, reset, err_ff != ERR_NONE && !(is_token && item.last_token), err_ff == $past(err_ff) && err_pos_ff == $past(err_pos_ff))

endmodule

`default_nettype wire

>>> rtl/sfe_rsp_queue.sv
// Small result queue that separates the evaluator from the result consumer.
`timescale 1ns / 1ps
`default_nettype none
`include "slicing_floorplan_size_eval_unit_macros.svh"

module sfe_rsp_queue
   import sfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   input  rsp_type              wr_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_item,
   output logic [RSP_CNT_W-1:0] count
);

   rsp_type              slot_ff [RSP_SLOTS];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;

   function automatic logic [RSP_PTR_W-1:0] ptr_next(input logic [RSP_PTR_W-1:0] p);
      return (p == RSP_PTR_W'(RSP_SLOTS - 1)) ? '0 : p + RSP_PTR_W'(1);
   endfunction

   assign pop = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_valid ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      unique case ({wr_valid, pop})
         2'b10:   count_in = count_ff + RSP_CNT_W'(1);
         2'b01:   count_in = count_ff - RSP_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   `SFE_ASSERT_SAME(a_no_write_when_full, clock, reset, wr_valid, count_ff != RSP_CNT_W'(RSP_SLOTS))
   `SFE_ASSERT_NEXT(a_count_up, clock, reset, wr_valid && !pop, count_ff == RSP_CNT_W'($past(count_ff) + RSP_CNT_W'(1)))
   `SFE_ASSERT_NEXT(a_count_down, clock, reset, pop && !wr_valid, count_ff == RSP_CNT_W'($past(count_ff) - RSP_CNT_W'(1)))

endmodule

`default_nettype wire

>>> rtl/slicing_floorplan_size_eval_unit.sv
// Top level of the slicing floorplan size evaluator: checker, cell chain, result queue.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   req     | in        | req_valid / req_ready | req_item  (load or expression token)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_item  (root size, error, position)
//
// One item is accepted per cycle while req_ready is high. After the last token of an
// expression is accepted, the token checker registers it, the cell chain forms the root
// from that register without a further register and the result queue captures it; the
// result can be taken from the queue from then on.
// Reset is synchronous and clears the control state only; the dimension store is
// undefined until loaded and needs no clearing pass.
// req_ready depends only on registers: it drops while three results are pending,
// which is the depth of the result queue.
`timescale 1ns / 1ps
`default_nettype none

module slicing_floorplan_size_eval_unit
   import sfe_pkg::*;
#(
   parameter int MAX_MODULES = MAX_MODULES_DEF,
   parameter int DIM_BITS    = DIM_BITS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   localparam int PEND_W = RSP_CNT_W + 1;

   logic                 accept;
   stage_type            stage;
   logic [RSP_CNT_W-1:0] q_count;
   logic [PEND_W-1:0]    pending;

   size_type cell_q     [STACK_DEPTH];
   size_type cell_above [STACK_DEPTH];
   size_type cell_below [STACK_DEPTH];

   size_type merged;
   size_type root;
   logic     wr_valid;
   rsp_type  wr_item;

   // Results in flight count against the queue, so the chain never has to stall.
   assign pending   = PEND_W'(q_count) + PEND_W'(stage.valid && stage.last);
   assign req_ready = pending < PEND_W'(RSP_SLOTS);
   assign accept    = req_valid && req_ready;

   // The checker decides each token's stack action and fault without waiting on
   // stack data, so the next token is checked while this one acts on the chain.
   sfe_token_ctrl #(
      .MAX_MODULES (MAX_MODULES),
      .DIM_BITS    (DIM_BITS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_item),
      .stage  (stage)
   );

   // Cell 0 is the stack top. A cut merges the two top entries into cell 0 and
   // every deeper cell takes the entry below it; a push shifts everything down.
   always_comb begin
      merged = cell_q[0];
      unique case (stage.op)
         OP_CUT_H: begin
            merged.w = (cell_q[0].w > cell_q[1].w) ? cell_q[0].w : cell_q[1].w;
            merged.h = sat_size(33'(cell_q[0].h) + 33'(cell_q[1].h));
         end
         OP_CUT_V: begin
            merged.w = sat_size(33'(cell_q[0].w) + 33'(cell_q[1].w));
            merged.h = (cell_q[0].h > cell_q[1].h) ? cell_q[0].h : cell_q[1].h;
         end
         OP_PUSH, OP_NONE: begin
            merged = cell_q[0];
         end
      endcase
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
         assign cell_above[i] = stage.push_val;
         assign cell_below[i] = merged;
      end else if (i == STACK_DEPTH - 1) begin : g_bottom
         assign cell_above[i] = cell_q[i-1];
         assign cell_below[i] = cell_q[i];
      end else begin : g_mid
         assign cell_above[i] = cell_q[i-1];
         assign cell_below[i] = cell_q[i+1];
      end

      sfe_stack_cell u_cell (
         .clock (clock),
         .op    (stage.op),
         .above (cell_above[i]),
         .below (cell_below[i]),
         .q     (cell_q[i])
      );
   end

   // With no fault the final depth is one, so the root is what cell 0 takes now.
   always_comb begin
      unique case (stage.op)
         OP_PUSH:            root = stage.push_val;
         OP_CUT_H, OP_CUT_V: root = merged;
         OP_NONE:            root = cell_q[0];
      endcase
   end

   assign wr_valid = stage.valid && stage.last;

   always_comb begin
      if (stage.err_code == ERR_NONE) begin
         wr_item.total_width    = root.w;
         wr_item.total_height   = root.h;
         wr_item.error_code     = ERR_NONE;
         wr_item.fault_position = '0;
      end else begin
         wr_item.total_width    = '0;
         wr_item.total_height   = '0;
         wr_item.error_code     = stage.err_code;
         wr_item.fault_position = stage.err_pos;
      end
   end

   sfe_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_valid  (wr_valid),
      .wr_item   (wr_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .count     (q_count)
   );

endmodule

`default_nettype wire

>>> sim/tb_slicing_floorplan_size_eval_unit.sv
// Self-checking testbench for the slicing floorplan size evaluator top level.
`timescale 1ns / 1ps

module tb_slicing_floorplan_size_eval_unit;
   import sfe_pkg::*;

   // Clock, reset and the two item channels. Every input has a known value from time zero.
   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   slicing_floorplan_size_eval_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bookkeeping for the run.
   int fail_count       = 0;
   int items_sent       = 0;
   int expressions_sent = 0;
   int roots_checked    = 0;
   int faults_by_code [0:int'(ERR_OVERFLOW)];

   // Idle rates in percent for the sender and the receiver, and the share of
   // load items mixed in between the tokens of an expression.
   int src_idle_pct    = 0;
   int sink_idle_pct   = 0;
   int load_mix_pct    = 0;
   int sink_stall_left = 0;

   // Shadow of the block: the dimension store, the slice stack and the
   // expression bookkeeping. The store is only read for modules that the
   // first test has loaded, so it never needs a reset value here.
   logic [LOAD_W-1:0] mod_w [MAX_MODULES_DEF];
   logic [LOAD_W-1:0] mod_h [MAX_MODULES_DEF];
   logic [SIZE_W-1:0] slice_w [STACK_DEPTH_DEF];
   logic [SIZE_W-1:0] slice_h [STACK_DEPTH_DEF];
   int                slice_depth = 0;
   logic              prev_valid  = 1'b0;
   mode_type          prev_mode   = MODE_LOAD;
   logic [IDX_W-1:0]  prev_idx    = '0;
   logic [POS_W-1:0]  tok_index   = '0;
   err_type           fault_code  = ERR_NONE;
   logic [POS_W-1:0]  fault_at    = '0;

   // Root sizes and fault reports still owed by the block, oldest first.
   rsp_type expected_roots[$];

   // Token sequence of the expression being built.
   req_type expr_q[$];

   function automatic logic [SIZE_W-1:0] clamp_sum(input logic [SIZE_W-1:0] a,
                                                   input logic [SIZE_W-1:0] b);
      logic [SIZE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      // The size limit is all ones, so a carry out is exactly an overflow.
      return s[SIZE_W] ? SIZE_LIMIT : s[SIZE_W-1:0];
   endfunction

   function automatic logic [SIZE_W-1:0] wider(input logic [SIZE_W-1:0] a,
                                               input logic [SIZE_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // Only the first fault of an expression is kept.
   function automatic void note_fault(input err_type code);
      if (fault_code == ERR_NONE) begin
         fault_code = code;
         fault_at   = tok_index;
      end
   endfunction

   function automatic void clear_expression();
      slice_depth = 0;
      prev_valid  = 1'b0;
      tok_index   = '0;
      fault_code  = ERR_NONE;
      fault_at    = '0;
   endfunction

   // Applies one accepted item to the shadow state and queues the root
   // report when the item closes an expression.
   function automatic void predict_floorplan(input req_type it);
      logic [SIZE_W-1:0] w1, h1, w2, h2;
      rsp_type           root;
      if (it.mode == MODE_LOAD) begin
         mod_w[it.module_index] = it.load_width;
         mod_h[it.module_index] = it.load_height;
      end else begin
         if (fault_code == ERR_NONE) begin
            if (it.mode == MODE_OPERAND) begin
               if (prev_valid && prev_mode == MODE_OPERAND && prev_idx == it.module_index) begin
                  note_fault(ERR_REPEAT);
               end else if (slice_depth >= STACK_DEPTH_DEF) begin
                  note_fault(ERR_OVERFLOW);
               end else begin
                  slice_w[slice_depth] = SIZE_W'(mod_w[it.module_index]);
                  slice_h[slice_depth] = SIZE_W'(mod_h[it.module_index]);
                  slice_depth++;
               end
            end else begin
               // Underflow wins over a repeated cut.
               if (slice_depth < 2) begin
                  note_fault(ERR_UNDERFLOW);
               end else if (prev_valid && prev_mode == it.mode) begin
                  note_fault(ERR_REPEAT);
               end else begin
                  w1 = slice_w[slice_depth-1];
                  h1 = slice_h[slice_depth-1];
                  w2 = slice_w[slice_depth-2];
                  h2 = slice_h[slice_depth-2];
                  if (it.mode == MODE_CUT_H) begin
                     slice_w[slice_depth-2] = wider(w1, w2);
                     slice_h[slice_depth-2] = clamp_sum(h1, h2);
                  end else begin
                     slice_w[slice_depth-2] = clamp_sum(w1, w2);
                     slice_h[slice_depth-2] = wider(h1, h2);
                  end
                  slice_depth--;
               end
            end
         end
         prev_valid = 1'b1;
         prev_mode  = it.mode;
         prev_idx   = it.module_index;
         if (!it.last_token) begin
            if (tok_index != POS_LIMIT) tok_index++;
         end else begin
            if (fault_code == ERR_NONE && slice_depth != 1) note_fault(ERR_UNBALANCED);
            if (fault_code == ERR_NONE) begin
               root.total_width    = slice_w[0];
               root.total_height   = slice_h[0];
               root.error_code     = ERR_NONE;
               root.fault_position = '0;
            end else begin
               root.total_width    = '0;
               root.total_height   = '0;
               root.error_code     = fault_code;
               root.fault_position = fault_at;
            end
            expected_roots.insert(expected_roots.size(), root);
            clear_expression();
         end
      end
   endfunction

   // Result channel: rsp_ready drops in random stall bursts.
   always @(posedge clock) begin
      if (sink_stall_left != 0) begin
         sink_stall_left <= sink_stall_left - 1;
         rsp_ready       <= 1'b0;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
         sink_stall_left <= $urandom_range(0, 5);
         rsp_ready       <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Every accepted result is held against the oldest outstanding root.
   always @(posedge clock) begin : root_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_roots.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual w %0d h %0d code %0d pos %0d",
                     $time, rsp_item.total_width, rsp_item.total_height,
                     rsp_item.error_code, rsp_item.fault_position);
            fail_count++;
         end else begin
            want = expected_roots.pop_front();
            roots_checked++;
            faults_by_code[want.error_code]++;
            check_field("total_width", 32'(want.total_width), 32'(rsp_item.total_width));
            check_field("total_height", 32'(want.total_height), 32'(rsp_item.total_height));
            check_field("error_code", 32'(want.error_code), 32'(rsp_item.error_code));
            check_field("fault_position", 32'(want.fault_position),
                        32'(rsp_item.fault_position));
         end
      end
   end

   function automatic req_type make_token(input mode_type m, input logic [IDX_W-1:0] idx);
      req_type t;
      t.mode         = m;
      t.module_index = idx;
      // The load fields are don't-care on tokens, so they carry noise.
      t.load_width   = LOAD_W'($urandom);
      t.load_height  = LOAD_W'($urandom);
      t.last_token   = 1'b0;
      return t;
   endfunction

   // Loads carry a random end flag, which the block must ignore.
   function automatic req_type make_load(input logic [IDX_W-1:0] idx,
                                         input logic [LOAD_W-1:0] w,
                                         input logic [LOAD_W-1:0] h);
      req_type t;
      t.mode         = MODE_LOAD;
      t.module_index = idx;
      t.load_width   = w;
      t.load_height  = h;
      t.last_token   = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic void add_token(input mode_type m, input logic [IDX_W-1:0] idx);
      expr_q.insert(expr_q.size(), make_token(m, idx));
   endfunction

   // Offers one item, possibly after an idle burst, and holds it until the
   // block takes it. The shadow is updated at the edge of acceptance.
   task automatic send_item(input req_type it);
      int gap;
      if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_floorplan(it);
      items_sent++;
   endtask

   // Sends the built expression; the end flag goes on its final token.
   task automatic send_expression();
      req_type t;
      for (int i = 0; i < expr_q.size(); i++) begin
         if (load_mix_pct != 0 && $urandom_range(0, 99) < load_mix_pct)
            send_item(make_load(IDX_W'($urandom), LOAD_W'($urandom), LOAD_W'($urandom)));
         t = expr_q[i];
         if (t.mode != MODE_LOAD) t.last_token = (i == expr_q.size() - 1);
         send_item(t);
      end
      expressions_sent++;
   endtask

   // Stops sending and waits until every owed root has come back.
   task automatic drain_roots();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_roots.size() != 0) @(posedge clock);
   endtask

   // A chain that alternates operands a and b with one kind of cut; with
   // dangling set, one operand too many is left on the stack at the end.
   function automatic void build_chain(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                                       input mode_type cut, input int n_cuts,
                                       input bit dangling);
      expr_q.delete();
      add_token(MODE_OPERAND, a);
      for (int i = 0; i < n_cuts; i++) begin
         add_token(MODE_OPERAND, (i % 2 == 1) ? a : b);
         add_token(cut, IDX_W'($urandom));
      end
      if (dangling) add_token(MODE_OPERAND, b);
   endfunction

   // Pushes n_leaves operands and then folds them with alternating cuts.
   function automatic void build_tower(input int n_leaves, input int n_cuts);
      expr_q.delete();
      for (int i = 0; i < n_leaves; i++)
         add_token(MODE_OPERAND, (i % 2 == 1) ? IDX_W'(63) : IDX_W'(0));
      for (int i = 0; i < n_cuts; i++)
         add_token((i % 2 == 1) ? MODE_CUT_V : MODE_CUT_H, IDX_W'($urandom));
   endfunction

   // Random normalized expression over n_leaves modules: no cut with fewer
   // than two slices below it, no token repeated back to back.
   function automatic void build_wellformed(input int n_leaves);
      int               d;
      int               left;
      mode_type         m;
      logic [IDX_W-1:0] idx;
      logic             have_prev;
      mode_type         pm;
      logic [IDX_W-1:0] pidx;
      expr_q.delete();
      d         = 0;
      left      = n_leaves;
      have_prev = 1'b0;
      pm        = MODE_LOAD;
      pidx      = '0;
      while (left > 0 || d > 1) begin
         idx = IDX_W'($urandom);
         if (left > 0 && (d < 2 || $urandom_range(0, 1) == 1)) begin
            m = MODE_OPERAND;
            if (have_prev && pm == MODE_OPERAND && pidx == idx) idx = idx + 1'b1;
            d++;
            left--;
         end else begin
            m = ($urandom_range(0, 1) == 1) ? MODE_CUT_H : MODE_CUT_V;
            if (have_prev && pm == m) m = (m == MODE_CUT_H) ? MODE_CUT_V : MODE_CUT_H;
            d--;
         end
         add_token(m, idx);
         have_prev = 1'b1;
         pm        = m;
         pidx      = idx;
      end
   endfunction

   // Damages a built expression: a doubled token, a dropped one or a token
   // whose kind is redrawn at random.
   function automatic void break_expression();
      int      at;
      req_type t;
      at = $urandom_range(0, expr_q.size() - 1);
      case ($urandom_range(0, 2))
         0: begin
            expr_q.insert(at, expr_q[at]);
         end
         1: begin
            if (expr_q.size() > 1) expr_q.delete(at);
         end
         default: begin
            t          = expr_q[at];
            t.mode     = mode_type'($urandom_range(1, 3));
            expr_q[at] = t;
         end
      endcase
   endfunction

   // Unstructured tokens over a handful of modules, so repeats are common.
   function automatic void build_noise(input int n_tokens);
      expr_q.delete();
      for (int i = 0; i < n_tokens; i++)
         add_token(mode_type'($urandom_range(1, 3)), IDX_W'($urandom_range(0, 3)));
   endfunction

   // Fills the whole dimension store. The corner modules hold the extreme
   // sizes that the directed tests rely on.
   task automatic test_module_loads();
      send_item(make_load(IDX_W'(0), 16'hFFFF, 16'h0001));
      send_item(make_load(IDX_W'(1), 16'h0000, 16'hFFFF));
      send_item(make_load(IDX_W'(2), 16'h0000, 16'h0000));
      send_item(make_load(IDX_W'(63), 16'hFFFF, 16'hFFFF));
      for (int m = 3; m < 63; m++)
         send_item(make_load(IDX_W'(m), LOAD_W'($urandom), LOAD_W'($urandom)));
   endtask

   // Single module, each cut on its own, and a load between two tokens.
   task automatic test_basic_cuts();
      expr_q.delete();
      add_token(MODE_OPERAND, IDX_W'(63));
      send_expression();
      expr_q.delete();
      add_token(MODE_OPERAND, IDX_W'(0));
      add_token(MODE_OPERAND, IDX_W'(1));
      add_token(MODE_CUT_H, IDX_W'(0));
      send_expression();
      expr_q.delete();
      add_token(MODE_OPERAND, IDX_W'(1));
      add_token(MODE_OPERAND, IDX_W'(0));
      add_token(MODE_CUT_V, IDX_W'(63));
      send_expression();
      expr_q.delete();
      add_token(MODE_OPERAND, IDX_W'(63));
      add_token(MODE_OPERAND, IDX_W'(2));
      add_token(MODE_CUT_H, IDX_W'(0));
      expr_q.insert(expr_q.size(), make_load(IDX_W'(5), 16'h00A0, 16'h0B00));
      add_token(MODE_OPERAND, IDX_W'(5));
      add_token(MODE_CUT_V, IDX_W'(0));
      send_expression();
   endtask

   // Underflow, repeat and unbalanced faults, the priority of underflow over a
   // repeated cut, and tokens that follow a fault.
   task automatic test_fault_detection();
      expr_q.delete();
      add_token(MODE_CUT_V, IDX_W'(0));
      send_expression();
      expr_q.delete();
      add_token(MODE_OPERAND, IDX_W'(0));
      add_token(MODE_CUT_H, IDX_W'(0));
      send_expression();
      expr_q.delete();
      add_token(MODE_OPERAND, IDX_W'(0));
      add_token(MODE_OPERAND, IDX_W'(1));
      add_token(MODE_CUT_V, IDX_W'(0));
      add_token(MODE_CUT_V, IDX_W'(0));
      send_expression();
      expr_q.delete();
      add_token(MODE_OPERAND, IDX_W'(3));
      add_token(MODE_OPERAND, IDX_W'(3));
      send_expression();
      expr_q.delete();
      add_token(MODE_OPERAND, IDX_W'(0));
      add_token(MODE_OPERAND, IDX_W'(1));
      add_token(MODE_OPERAND, IDX_W'(2));
      add_token(MODE_CUT_H, IDX_W'(0));
      add_token(MODE_CUT_H, IDX_W'(0));
      send_expression();
      expr_q.delete();
      add_token(MODE_OPERAND, IDX_W'(0));
      add_token(MODE_OPERAND, IDX_W'(1));
      send_expression();
      expr_q.delete();
      add_token(MODE_OPERAND, IDX_W'(0));
      add_token(MODE_CUT_H, IDX_W'(0));
      add_token(MODE_OPERAND, IDX_W'(1));
      add_token(MODE_OPERAND, IDX_W'(2));
      add_token(MODE_CUT_V, IDX_W'(0));
      send_expression();
   endtask

   // A full stack folded back to one slice, then one operand past the top, alone and with cuts after it.
   task automatic test_stack_extremes();
      build_tower(STACK_DEPTH_DEF, STACK_DEPTH_DEF - 1);
      send_expression();
      build_tower(STACK_DEPTH_DEF + 1, 0);
      send_expression();
      build_tower(STACK_DEPTH_DEF + 1, 3);
      send_expression();
   endtask

   // Long chains of full-size modules drive both sums into the limit; the
   // last one also runs the token index into its limit before the fault.
   task automatic test_size_saturation();
      build_chain(IDX_W'(0), IDX_W'(63), MODE_CUT_V, 70, 1'b0);
      send_expression();
      build_chain(IDX_W'(1), IDX_W'(63), MODE_CUT_H, 70, 1'b0);
      send_expression();
      build_chain(IDX_W'(1), IDX_W'(63), MODE_CUT_H, 70, 1'b1);
      send_expression();
   endtask

   // Mostly normalized expressions with random content, some damaged ones
   // and some noise, with loads mixed in. Idle rates change every sixteen
   // expressions; halfway the sender waits for all roots, and the final
   // stretch runs without any idling.
   task automatic test_random_expressions(input int n_items);
      int stop_at;
      int calm_at;
      int pick;
      int n;
      bit drained;
      stop_at      = items_sent + n_items;
      calm_at      = stop_at - 300;
      drained      = 1'b0;
      load_mix_pct = 8;
      while (items_sent < stop_at) begin
         if (items_sent >= calm_at) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end else if (expressions_sent % 16 == 0) begin
            src_idle_pct  = 15 * $urandom_range(0, 2);
            sink_idle_pct = 15 * $urandom_range(0, 2);
         end
         if (!drained && items_sent >= stop_at - n_items / 2) begin
            drain_roots();
            drained = 1'b1;
         end
         n    = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            build_wellformed(n);
         end else if (pick < 85) begin
            build_wellformed(n);
            break_expression();
         end else begin
            build_noise($urandom_range(1, 12));
         end
         send_expression();
      end
      load_mix_pct = 0;
   endtask

   initial begin
      foreach (faults_by_code[i]) faults_by_code[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // The directed part runs with light idling on both sides.
      src_idle_pct  = 20;
      sink_idle_pct = 20;
      test_module_loads();
      drain_roots();
      test_basic_cuts();
      drain_roots();
      test_fault_detection();
      drain_roots();
      test_stack_extremes();
      drain_roots();
      test_size_saturation();
      drain_roots();
      test_random_expressions(1200);
      drain_roots();
      // Keep the clock running to catch any stray results.
      repeat (8) @(posedge clock);
      $display("Summary: %0d items in %0d expressions, %0d roots checked, %0d fitted cleanly.",
               items_sent, expressions_sent, roots_checked, faults_by_code[ERR_NONE]);
      $display("Faults seen: %0d underflow, %0d repeated, %0d unbalanced, %0d overflow.",
               faults_by_code[ERR_UNDERFLOW], faults_by_code[ERR_REPEAT],
               faults_by_code[ERR_UNBALANCED], faults_by_code[ERR_OVERFLOW]);
      if (fail_count == 0) begin
         $display("slicing_floorplan_size_eval_unit regression: pass");
      end else begin
         $display("slicing_floorplan_size_eval_unit regression: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #3_000_000;
      $display("%0t: run timed out with %0d roots outstanding", $time, expected_roots.size());
      $display("slicing_floorplan_size_eval_unit regression: fail");
      $finish;
   end

endmodule
